[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the axis-angle row rotator.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_HOLDS(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("pipeline assertion failed");
`define AST_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("pipeline assertion failed");
`else
`define AST_HOLDS(lbl, clk_i, rstn_i, ante, cons)
`define AST_NEXT(lbl, clk_i, rstn_i, ante, cons)
`endif
`endif

[rtl/aarm_pkg.sv]
// Package for the axis-angle row rotator: Q2.30 constants, sine polynomial
// coefficients and the rounded Q2.30 multiply and clamp functions.
// Depends on nothing.
`timescale 1ns / 1ps

package aarm_pkg;

	localparam int QW = 34;
	localparam int ACC_W = 98;

	typedef logic signed [QW-1:0] q30_t;

	localparam q30_t Q_ONE = 34'sd1073741824;
	localparam q30_t NEG_ONE = -34'sd1073741824;

	localparam q30_t SIN_COEF [7] = '{
		34'sd1686629713, 34'sd693598668, 34'sd85569306, 34'sd5026995,
		34'sd172272, 34'sd3864, 34'sd61
	};

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	function automatic q30_t mul_q30(input q30_t a, input q30_t b);
		logic signed [2*QW-1:0] prod;
		logic [2*QW-1:0] mag;
		logic [2*QW-31:0] rnd;
		prod = a * b;
		mag = prod[2*QW-1] ? $unsigned(-prod) : $unsigned(prod);
		mag = mag + 68'd536870912;
		rnd = mag[2*QW-1:30];
		return prod[2*QW-1] ? -$signed(QW'(rnd)) : $signed(QW'(rnd));
	endfunction

	function automatic q30_t clamp_q(input q30_t v, input q30_t lo);
		q30_t res;
		res = v;
		if (v > Q_ONE) begin
			res = Q_ONE;
		end else if (v < lo) begin
			res = lo;
		end
		return res;
	endfunction

endpackage

[rtl/axis_angle_rotate_matrix_row.sv]
// Axis-angle rotation of one row of a column-major 4x4 matrix, Q16.16 data.
// Depends on aarm_pkg and assert_macros.svh.
//
// One input beat carries the axis, the angle and the four row elements; one
// output beat carries the three rotated elements, column 3 copied, and the
// bad_axis flag. A beat moves when valid is high and stall is low.
// The block is a 75-stage pipeline that takes one beat in every cycle
// unless a stalled result holds it. Most of its stages go to the square root
// of the axis length (one result bit per stage, 32 stages) followed by the
// three axis divisions (one quotient bit per stage, 31 stages). The sine
// polynomial runs beside the root.
// When the receiver stalls a waiting result, the whole pipeline holds; the
// first stage still takes a beat while it is empty. A zero axis returns the
// row unchanged with bad_axis set. Reset clears only the valid bits.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module axis_angle_rotate_matrix_row #(
	parameter int ELEM_WIDTH = 32,
	parameter int ANGLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [ELEM_WIDTH-1:0] axis_x,
	input  logic signed [ELEM_WIDTH-1:0] axis_y,
	input  logic signed [ELEM_WIDTH-1:0] axis_z,
	input  logic        [ANGLE_BITS-1:0] turn_angle,
	input  logic signed [ELEM_WIDTH-1:0] in_c0,
	input  logic signed [ELEM_WIDTH-1:0] in_c1,
	input  logic signed [ELEM_WIDTH-1:0] in_c2,
	input  logic signed [ELEM_WIDTH-1:0] in_c3,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [ELEM_WIDTH-1:0] out_c0,
	output logic signed [ELEM_WIDTH-1:0] out_c1,
	output logic signed [ELEM_WIDTH-1:0] out_c2,
	output logic signed [ELEM_WIDTH-1:0] out_c3,
	output logic                         bad_axis
);

	import aarm_pkg::*;

	localparam int EW = ELEM_WIDTH;
	localparam int AB = ANGLE_BITS;
	localparam int BLW = $clog2(ELEM_WIDTH + 1);
	localparam int XSH = 32 - ANGLE_BITS;
	localparam int QB = 31;

	localparam int ST_X = 1;
	localparam int ST_X2 = 2;
	localparam int ST_H0 = 3;
	localparam int ST_SF = 9;
	localparam int ST_SC = 10;
	localparam int SQRT_BEG = 4;
	localparam int SQRT_STEPS = 32;
	localparam int SQRT_END = SQRT_BEG + SQRT_STEPS - 1;
	localparam int DIV_INIT = SQRT_END + 1;
	localparam int DIV_END = DIV_INIT + QB;
	localparam int ST_U = DIV_END + 1;
	localparam int ST_UU = ST_U + 1;
	localparam int ST_N = ST_UU + 1;
	localparam int ST_PP = ST_N + 1;
	localparam int ST_PR = ST_PP + 1;
	localparam int ST_ACC = ST_PR + 1;
	localparam int ST_OUT = ST_ACC + 1;
	localparam int LAT = ST_OUT + 1;

	localparam logic [AB-2:0] QTR = (AB-1)'(1) << (AB - 2);
	localparam logic [QB-1:0] Q_UNIT = 31'd1 << 30;
	localparam logic signed [ACC_W-1:0] SAT_MAX =
		$signed((ACC_W'(1) << (EW - 1)) - ACC_W'(1));
	localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;
	localparam logic signed [ACC_W-1:0] RND_HALF = $signed(ACC_W'(1) << 29);

	typedef struct packed {
		logic               bad;
		logic [2:0]         aneg;
		logic [2:0]         eneg;
		logic [2:0][EW-1:0] emag;
		logic [EW-1:0]      c3;
	} side_t;

	typedef struct packed {
		q30_t s;
		q30_t c;
		q30_t t;
	} trig_t;

	logic [LAT-1:0] vld_s;
	logic           adv;
	logic           en0;

	side_t              side_in;
	logic [2:0][EW-1:0] ax_raw;
	logic [2:0][EW-1:0] el_raw;
	logic [2:0][EW-1:0] amag_in;
	logic [EW-1:0]      big_in;

	side_t              side_s0;
	side_t              side_s [1:ST_ACC];
	logic [2:0][EW-1:0] amag_s0;
	logic [EW-1:0]      big_s0;
	logic [AB-1:0]      ang_s0;

	logic [BLW-1:0]        blen;
	logic [2:0][EW+30:0]   nwide;
	logic [2:0][QB-1:0]    nm_in;
	logic [AB-3:0]         frac;
	logic [AB-2:0]         cfrac;
	logic [2:0][QB-1:0]    nm_s [ST_X:SQRT_END];
	q30_t                  xs_s [ST_X:ST_SF-1];
	q30_t                  xc_s [ST_X:ST_SF-1];
	logic [1:0]            quad_s [ST_X:ST_SF];
	q30_t                  x2s_s [ST_X2:ST_SF-2];
	q30_t                  x2c_s [ST_X2:ST_SF-2];
	q30_t                  accs_s [ST_H0:ST_SF-1];
	q30_t                  accc_s [ST_H0:ST_SF-1];
	logic [2:0][2*QB-1:0]  sqp_s2;
	logic [63:0]           sqv_s [SQRT_BEG-1:SQRT_END];
	logic [63:0]           sqr_s [SQRT_BEG-1:SQRT_END];

	q30_t  sf_in;
	q30_t  cf_in;
	q30_t  sf_s9;
	q30_t  cf_s9;
	trig_t trig_in;
	trig_t trig_s [ST_SC:ST_N-1];

	logic [2:0][61:0]   rem_s [DIV_INIT:DIV_END];
	logic [2:0][QB-1:0] q_s [DIV_INIT:DIV_END];
	logic [31:0]        dvs_s [DIV_INIT:DIV_END];

	q30_t u_s68 [3];
	q30_t uu_s69 [6];
	q30_t us_s69 [3];
	q30_t ut [6];
	q30_t nraw [9];
	q30_t ncl [9];
	logic [8:0]    nneg_s70;
	logic [QB-1:0] nmag_s70 [9];
	logic [62:0]   lo_s71 [9];
	logic [62:0]   hi_s71 [9];
	logic [8:0]    pneg_s71;
	logic signed [ACC_W-1:0] prod_s72 [9];
	logic signed [ACC_W-1:0] rnd_s73 [3];
	logic signed [ACC_W-1:0] sum_acc [3];
	logic [EW-1:0]           sat_val [3];
	logic [EW-1:0]           pass_val [3];

	assign adv = !(vld_s[ST_OUT] && out_stall);
	assign en0 = adv || !vld_s[0];
	assign in_stall = !en0;
	assign out_valid = vld_s[ST_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end else if (!vld_s[0]) begin
			vld_s[0] <= in_valid;
		end
	end

	assign ax_raw = {axis_z, axis_y, axis_x};
	assign el_raw = {in_c2, in_c1, in_c0};

	always_comb begin
		side_in.bad = (ax_raw == '0);
		side_in.c3 = in_c3;
		for (int k = 0; k < 3; k++) begin
			side_in.aneg[k] = ax_raw[k][EW-1];
			side_in.eneg[k] = el_raw[k][EW-1];
			amag_in[k] = ax_raw[k][EW-1] ? (~ax_raw[k] + 1'b1) : ax_raw[k];
			side_in.emag[k] = el_raw[k][EW-1] ? (~el_raw[k] + 1'b1) : el_raw[k];
		end
		big_in = amag_in[0];
		if (amag_in[1] > big_in) begin
			big_in = amag_in[1];
		end
		if (amag_in[2] > big_in) begin
			big_in = amag_in[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en0) begin
			side_s0 <= side_in;
			amag_s0 <= amag_in;
			big_s0 <= big_in;
			ang_s0 <= turn_angle;
		end
	end

	always_comb begin
		blen = '0;
		for (int i = 0; i < EW; i++) begin
			if (big_s0[i]) begin
				blen = BLW'(i + 1);
			end
		end
		for (int k = 0; k < 3; k++) begin
			nwide[k] = {amag_s0[k], 31'b0} >> blen;
			nm_in[k] = nwide[k][QB-1:0];
		end
		frac = ang_s0[AB-3:0];
		cfrac = QTR - {1'b0, frac};
	end

	always_comb begin
		sf_in = clamp_q(mul_q30(xs_s[ST_SF-1], accs_s[ST_SF-1]), '0);
		if (xs_s[ST_SF-1] == '0) begin
			sf_in = '0;
		end else if (xs_s[ST_SF-1] >= Q_ONE) begin
			sf_in = Q_ONE;
		end
		cf_in = clamp_q(mul_q30(xc_s[ST_SF-1], accc_s[ST_SF-1]), '0);
		if (xc_s[ST_SF-1] == '0) begin
			cf_in = '0;
		end else if (xc_s[ST_SF-1] >= Q_ONE) begin
			cf_in = Q_ONE;
		end
	end

	always_comb begin
		case (quad_s[ST_SF])
			QUAD_0: begin
				trig_in.s = sf_s9;
				trig_in.c = cf_s9;
			end
			QUAD_1: begin
				trig_in.s = cf_s9;
				trig_in.c = -sf_s9;
			end
			QUAD_2: begin
				trig_in.s = -sf_s9;
				trig_in.c = -cf_s9;
			end
			default: begin
				trig_in.s = -cf_s9;
				trig_in.c = sf_s9;
			end
		endcase
		trig_in.t = Q_ONE - trig_in.c;
	end

	always_comb begin
		for (int p = 0; p < 6; p++) begin
			ut[p] = mul_q30(uu_s69[p], trig_s[ST_N-1].t);
		end
		nraw[0] = ut[0] + trig_s[ST_N-1].c;
		nraw[1] = ut[1] + us_s69[2];
		nraw[2] = ut[2] - us_s69[1];
		nraw[3] = ut[1] - us_s69[2];
		nraw[4] = ut[3] + trig_s[ST_N-1].c;
		nraw[5] = ut[4] + us_s69[0];
		nraw[6] = ut[2] + us_s69[1];
		nraw[7] = ut[4] - us_s69[0];
		nraw[8] = ut[5] + trig_s[ST_N-1].c;
		for (int k = 0; k < 9; k++) begin
			ncl[k] = clamp_q(nraw[k], NEG_ONE);
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sum_acc[j] = prod_s72[3*j] + prod_s72[3*j+1] + prod_s72[3*j+2] + RND_HALF;
			if (rnd_s73[j] > SAT_MAX) begin
				sat_val[j] = SAT_MAX[EW-1:0];
			end else if (rnd_s73[j] < SAT_MIN) begin
				sat_val[j] = SAT_MIN[EW-1:0];
			end else begin
				sat_val[j] = rnd_s73[j][EW-1:0];
			end
			pass_val[j] = side_s[ST_ACC].eneg[j] ? (~side_s[ST_ACC].emag[j] + 1'b1)
				: side_s[ST_ACC].emag[j];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[1] <= side_s0;
			for (int i = 2; i <= ST_ACC; i++) begin
				side_s[i] <= side_s[i-1];
			end
			nm_s[ST_X] <= nm_in;
			for (int i = ST_X + 1; i <= SQRT_END; i++) begin
				nm_s[i] <= nm_s[i-1];
			end
			xs_s[ST_X] <= $signed(QW'(frac) << XSH);
			xc_s[ST_X] <= $signed(QW'(cfrac) << XSH);
			quad_s[ST_X] <= ang_s0[AB-1 -: 2];
			for (int i = ST_X + 1; i < ST_SF; i++) begin
				xs_s[i] <= xs_s[i-1];
				xc_s[i] <= xc_s[i-1];
			end
			for (int i = ST_X + 1; i <= ST_SF; i++) begin
				quad_s[i] <= quad_s[i-1];
			end
			x2s_s[ST_X2] <= mul_q30(xs_s[ST_X], xs_s[ST_X]);
			x2c_s[ST_X2] <= mul_q30(xc_s[ST_X], xc_s[ST_X]);
			for (int i = ST_X2 + 1; i <= ST_SF - 2; i++) begin
				x2s_s[i] <= x2s_s[i-1];
				x2c_s[i] <= x2c_s[i-1];
			end
			for (int k = 0; k < 3; k++) begin
				sqp_s2[k] <= (2*QB)'(nm_s[ST_X][k]) * (2*QB)'(nm_s[ST_X][k]);
			end
			sqv_s[SQRT_BEG-1] <= 64'(sqp_s2[0]) + 64'(sqp_s2[1]) + 64'(sqp_s2[2]);
			sqr_s[SQRT_BEG-1] <= '0;
			sf_s9 <= sf_in;
			cf_s9 <= cf_in;
			trig_s[ST_SC] <= trig_in;
			for (int i = ST_SC + 1; i < ST_N; i++) begin
				trig_s[i] <= trig_s[i-1];
			end
			for (int k = 0; k < 3; k++) begin
				rem_s[DIV_INIT][k] <= (62'(nm_s[SQRT_END][k]) << 30)
					+ 62'(sqr_s[SQRT_END][31:1]);
				q_s[DIV_INIT][k] <= '0;
				u_s68[k] <= side_s[DIV_END].aneg[k] ? -$signed(QW'(q_s[DIV_END][k]))
					: $signed(QW'(q_s[DIV_END][k]));
				us_s69[k] <= mul_q30(u_s68[k], trig_s[ST_UU-1].s);
			end
			dvs_s[DIV_INIT] <= sqr_s[SQRT_END][31:0];
			uu_s69[0] <= mul_q30(u_s68[0], u_s68[0]);
			uu_s69[1] <= mul_q30(u_s68[1], u_s68[0]);
			uu_s69[2] <= mul_q30(u_s68[2], u_s68[0]);
			uu_s69[3] <= mul_q30(u_s68[1], u_s68[1]);
			uu_s69[4] <= mul_q30(u_s68[2], u_s68[1]);
			uu_s69[5] <= mul_q30(u_s68[2], u_s68[2]);
			for (int k = 0; k < 9; k++) begin
				nneg_s70[k] <= ncl[k][QW-1];
				nmag_s70[k] <= ncl[k][QW-1] ? QB'(-ncl[k]) : QB'(ncl[k]);
			end
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					lo_s71[3*j+k] <= 63'(64'(side_s[ST_PP-1].emag[k]) & 64'hFFFF_FFFF)
						* 63'(nmag_s70[3*j+k]);
					hi_s71[3*j+k] <= 63'(64'(side_s[ST_PP-1].emag[k]) >> 32)
						* 63'(nmag_s70[3*j+k]);
					pneg_s71[3*j+k] <= side_s[ST_PP-1].eneg[k] ^ nneg_s70[3*j+k];
				end
			end
			for (int k = 0; k < 9; k++) begin
				prod_s72[k] <= pneg_s71[k]
					? -$signed(ACC_W'(lo_s71[k]) + (ACC_W'(hi_s71[k]) << 32))
					: $signed(ACC_W'(lo_s71[k]) + (ACC_W'(hi_s71[k]) << 32));
			end
			for (int j = 0; j < 3; j++) begin
				rnd_s73[j] <= sum_acc[j] >>> 30;
			end
			out_c0 <= side_s[ST_ACC].bad ? pass_val[0] : sat_val[0];
			out_c1 <= side_s[ST_ACC].bad ? pass_val[1] : sat_val[1];
			out_c2 <= side_s[ST_ACC].bad ? pass_val[2] : sat_val[2];
			out_c3 <= side_s[ST_ACC].c3;
			bad_axis <= side_s[ST_ACC].bad;
		end
	end

	for (genvar h = 0; h < 6; h++) begin : g_horner
		q30_t prev_s;
		q30_t prev_c;
		if (h == 0) begin : g_first
			assign prev_s = SIN_COEF[6];
			assign prev_c = SIN_COEF[6];
		end else begin : g_rest
			assign prev_s = accs_s[ST_H0+h-1];
			assign prev_c = accc_s[ST_H0+h-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				accs_s[ST_H0+h] <= SIN_COEF[5-h] - mul_q30(x2s_s[ST_H0+h-1], prev_s);
				accc_s[ST_H0+h] <= SIN_COEF[5-h] - mul_q30(x2c_s[ST_H0+h-1], prev_c);
			end
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_root
		localparam logic [63:0] RBIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;
		assign trial = sqr_s[SQRT_BEG+k-1] + RBIT;
		always_ff @(posedge clk) begin
			if (adv) begin
				if (sqv_s[SQRT_BEG+k-1] >= trial) begin
					sqv_s[SQRT_BEG+k] <= sqv_s[SQRT_BEG+k-1] - trial;
					sqr_s[SQRT_BEG+k] <= (sqr_s[SQRT_BEG+k-1] >> 1) + RBIT;
				end else begin
					sqv_s[SQRT_BEG+k] <= sqv_s[SQRT_BEG+k-1];
					sqr_s[SQRT_BEG+k] <= sqr_s[SQRT_BEG+k-1] >> 1;
				end
			end
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int SH = QB - 1 - j;
		logic [62:0]        dsh;
		logic [2:0][61:0]   rem_nx;
		logic [2:0][QB-1:0] q_nx;
		assign dsh = 63'(dvs_s[DIV_INIT+j]) << SH;
		always_comb begin
			for (int k = 0; k < 3; k++) begin
				rem_nx[k] = rem_s[DIV_INIT+j][k];
				q_nx[k] = q_s[DIV_INIT+j][k];
				if ({1'b0, rem_s[DIV_INIT+j][k]} >= dsh) begin
					rem_nx[k] = rem_s[DIV_INIT+j][k] - dsh[61:0];
					q_nx[k][SH] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[DIV_INIT+j+1] <= rem_nx;
				q_s[DIV_INIT+j+1] <= q_nx;
				dvs_s[DIV_INIT+j+1] <= dvs_s[DIV_INIT+j];
			end
		end
	end

	`AST_HOLDS(a_root_range, clk, arst_n, vld_s[SQRT_END] && !side_s[SQRT_END].bad, sqr_s[SQRT_END][63:32] == 32'd0 && sqr_s[SQRT_END][31:30] != 2'd0)
	`AST_HOLDS(a_quot_range, clk, arst_n, vld_s[DIV_END] && !side_s[DIV_END].bad, q_s[DIV_END][0] <= Q_UNIT && q_s[DIV_END][1] <= Q_UNIT && q_s[DIV_END][2] <= Q_UNIT)
	`AST_HOLDS(a_unit_nonzero, clk, arst_n, vld_s[DIV_END] && !side_s[DIV_END].bad, (q_s[DIV_END][0] | q_s[DIV_END][1] | q_s[DIV_END][2]) != '0)
	`AST_HOLDS(a_trig_range, clk, arst_n, vld_s[ST_SC], trig_s[ST_SC].s <= Q_ONE && trig_s[ST_SC].s >= NEG_ONE && trig_s[ST_SC].c <= Q_ONE && trig_s[ST_SC].c >= NEG_ONE)

endmodule

[sim/axis_angle_rotate_matrix_row_chk.sv]
// Checker for the axis-angle row rotator: watches both channels, predicts each
// output beat from the accepted input beat and compares field by field.
// Depends on aarm_pkg for the sine polynomial coefficients.
`timescale 1ns / 1ps

module axis_angle_rotate_matrix_row_chk (
	input  logic               clk,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] axis_x,
	input  logic signed [31:0] axis_y,
	input  logic signed [31:0] axis_z,
	input  logic        [15:0] turn_angle,
	input  logic signed [31:0] in_c0,
	input  logic signed [31:0] in_c1,
	input  logic signed [31:0] in_c2,
	input  logic signed [31:0] in_c3,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] out_c0,
	input  logic signed [31:0] out_c1,
	input  logic signed [31:0] out_c2,
	input  logic signed [31:0] out_c3,
	input  logic               bad_axis,
	output int                 fails,
	output int                 pending
);

	localparam longint ONE_Q30 = 64'sd1073741824;

	typedef struct packed {
		logic signed [31:0] c0;
		logic signed [31:0] c1;
		logic signed [31:0] c2;
		logic signed [31:0] c3;
		logic               bad;
	} rot_row_t;

	rot_row_t rows_due[$];

	function automatic longint qmul(longint a, longint b);
		longint p;
		p = a * b;
		if (p >= 0) begin
			return (p + (64'sd1 <<< 29)) >>> 30;
		end
		return -((-p + (64'sd1 <<< 29)) >>> 30);
	endfunction

	function automatic longint clamp_q(longint v, longint lo);
		if (v > ONE_Q30) begin
			return ONE_Q30;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	function automatic longint quarter_sine(longint x);
		longint x2, acc;
		if (x <= 0) begin
			return 0;
		end
		if (x >= ONE_Q30) begin
			return ONE_Q30;
		end
		x2 = qmul(x, x);
		acc = longint'(aarm_pkg::SIN_COEF[6]);
		for (int k = 5; k >= 0; k--) begin
			acc = longint'(aarm_pkg::SIN_COEF[k]) - qmul(x2, acc);
		end
		return clamp_q(qmul(x, acc), 0);
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) begin
			b = b >> 2;
		end
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic rot_row_t rotate_row(logic signed [31:0] ax[3], logic [15:0] ang,
			logic signed [31:0] el[4]);
		rot_row_t res;
		logic [63:0] mag[3];
		logic [63:0] big, sq, r;
		longint u[3], n[9], s, c, t, sf, cf;
		logic [15:0] f;
		logic signed [127:0] acc;
		int bl;
		big = 0;
		sq = 0;
		for (int k = 0; k < 3; k++) begin
			mag[k] = ax[k][31] ? 64'(-longint'(ax[k])) : 64'(ax[k]);
			if (mag[k] > big) begin
				big = mag[k];
			end
		end
		res.c3 = el[3];
		if (big == 0) begin
			res.c0 = el[0];
			res.c1 = el[1];
			res.c2 = el[2];
			res.bad = 1'b1;
			return res;
		end
		bl = 0;
		for (int k = 0; k < 64; k++) begin
			if (big[k]) begin
				bl = k + 1;
			end
		end
		for (int k = 0; k < 3; k++) begin
			mag[k] = (bl > 31) ? (mag[k] >> (bl - 31)) : (mag[k] << (31 - bl));
			sq = sq + mag[k] * mag[k];
		end
		r = int_sqrt(sq);
		for (int k = 0; k < 3; k++) begin
			u[k] = longint'(((mag[k] << 30) + (r >> 1)) / r);
			if (ax[k][31]) begin
				u[k] = -u[k];
			end
		end
		f = ang & 16'h3fff;
		sf = quarter_sine(longint'(f) <<< 16);
		cf = quarter_sine((64'sd16384 - longint'(f)) <<< 16);
		case (ang[15:14])
			aarm_pkg::QUAD_0: begin
				s = sf;
				c = cf;
			end
			aarm_pkg::QUAD_1: begin
				s = cf;
				c = -sf;
			end
			aarm_pkg::QUAD_2: begin
				s = -sf;
				c = -cf;
			end
			default: begin
				s = -cf;
				c = sf;
			end
		endcase
		t = ONE_Q30 - c;
		n[0] = qmul(qmul(u[0], u[0]), t) + c;
		n[1] = qmul(qmul(u[1], u[0]), t) + qmul(u[2], s);
		n[2] = qmul(qmul(u[2], u[0]), t) - qmul(u[1], s);
		n[3] = qmul(qmul(u[0], u[1]), t) - qmul(u[2], s);
		n[4] = qmul(qmul(u[1], u[1]), t) + c;
		n[5] = qmul(qmul(u[2], u[1]), t) + qmul(u[0], s);
		n[6] = qmul(qmul(u[0], u[2]), t) + qmul(u[1], s);
		n[7] = qmul(qmul(u[1], u[2]), t) - qmul(u[0], s);
		n[8] = qmul(qmul(u[2], u[2]), t) + c;
		for (int k = 0; k < 9; k++) begin
			n[k] = clamp_q(n[k], -ONE_Q30);
		end
		for (int j = 0; j < 3; j++) begin
			acc = 0;
			for (int k = 0; k < 3; k++) begin
				acc = acc + 128'(el[k]) * 128'(n[3 * j + k]);
			end
			acc = (acc + (128'sd1 <<< 29)) >>> 30;
			if (acc > 128'sd2147483647) begin
				acc = 128'sd2147483647;
			end else if (acc < -128'sd2147483648) begin
				acc = -128'sd2147483648;
			end
			case (j)
				0: res.c0 = acc[31:0];
				1: res.c1 = acc[31:0];
				default: res.c2 = acc[31:0];
			endcase
		end
		res.bad = 1'b0;
		return res;
	endfunction

	initial begin
		fails = 0;
	end

	assign pending = rows_due.size();

	always @(posedge clk) begin
		logic signed [31:0] ax[3];
		logic signed [31:0] el[4];
		rot_row_t want, got;
		if (in_valid && !in_stall) begin
			ax = '{axis_x, axis_y, axis_z};
			el = '{in_c0, in_c1, in_c2, in_c3};
			rows_due.push_back(rotate_row(ax, turn_angle, el));
		end
		if (out_valid && !out_stall) begin
			got = '{out_c0, out_c1, out_c2, out_c3, bad_axis};
			if (rows_due.size() == 0) begin
				fails++;
				if (fails <= 10) begin
					$display("Unexpected output beat: %h", got);
				end
			end else begin
				want = rows_due.pop_front();
				if (got !== want) begin
					fails++;
					if (fails <= 10) begin
						$display("Mismatch: expected c0=%h c1=%h c2=%h c3=%h bad=%b",
							want.c0, want.c1, want.c2, want.c3, want.bad);
						$display("          actual   c0=%h c1=%h c2=%h c3=%h bad=%b",
							got.c0, got.c1, got.c2, got.c3, got.bad);
					end
				end
			end
		end
	end

endmodule

[sim/axis_angle_rotate_matrix_row_tb.sv]
// Testbench top for the axis-angle row rotator: clock, reset, directed and
// random row beats with random idling on both sides, and the verdict.
// Depends on axis_angle_rotate_matrix_row and axis_angle_rotate_matrix_row_chk.
`timescale 1ns / 1ps

module axis_angle_rotate_matrix_row_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ROWS = 550;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] axis_x = '0;
	logic signed [31:0] axis_y = '0;
	logic signed [31:0] axis_z = '0;
	logic [15:0] turn_angle = '0;
	logic signed [31:0] in_c0 = '0;
	logic signed [31:0] in_c1 = '0;
	logic signed [31:0] in_c2 = '0;
	logic signed [31:0] in_c3 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] out_c0, out_c1, out_c2, out_c3;
	logic bad_axis;
	int fails, pending;

	logic beat_taken = 1'b0;
	int cycles = 0;
	int rows_sent = 0;
	int tx_idle_pct = 25;
	int rx_stall_pct = 54;
	int hold_left = 0;
	logic hold_done = 1'b0;

	axis_angle_rotate_matrix_row dut (.*);

	axis_angle_rotate_matrix_row_chk chk (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		beat_taken <= in_valid && !in_stall;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && rows_sent >= 120) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			out_stall <= 1'b1;
		end else begin
			out_stall <= $urandom_range(99) < rx_stall_pct;
		end
	end

	task automatic send_row(logic signed [31:0] ax, ay, az, logic [15:0] ang,
			logic signed [31:0] e0, e1, e2, e3);
		axis_x <= ax;
		axis_y <= ay;
		axis_z <= az;
		turn_angle <= ang;
		in_c0 <= e0;
		in_c1 <= e1;
		in_c2 <= e2;
		in_c3 <= e3;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
		end while (!beat_taken);
		rows_sent++;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	function automatic logic signed [31:0] pick_elem();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(2097152)) - 32'sd1048576;
			3: return 0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_axis();
		case ($urandom_range(7))
			0: return 0;
			1: return $signed($urandom_range(16)) - 32'sd8;
			2: return 32'sh80000000;
			3: return $signed($urandom_range(262144)) - 32'sd131072;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic signed [31:0] ax, ay, az;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_row(0, 0, 0, 16'd1234, 32'sh7fffffff, 32'sh80000000, 5, -7);
		send_row(0, 0, 0, 16'hffff, 1, 2, 3, 32'sh80000000);
		send_row(32'sh00010000, 0, 0, 16'd0, 32'sh00010000, 32'sh00020000, 3, 4);
		send_row(0, 32'sh00010000, 0, 16'd16384, 32'sh00010000, 32'sh00020000, 3, 4);
		send_row(0, 0, 32'sh00010000, 16'd32768, 32'sh00010000, -32'sh00020000, 3, 4);
		send_row(0, 0, -32'sh00010000, 16'd49152, 32'sh00010000, 32'sh00020000, 3, 4);
		send_row(1, 1, 1, 16'hffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff);
		send_row(1, 1, 1, 16'd8192, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000);
		send_row(32'sh7fffffff, 1, -1, 16'd1, 32'sh7fffffff, 0, 0, 0);
		send_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 16'd16383,
			32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0);
		send_row(32'sh80000000, 2, 0, 16'd16385, 32'sh80000000, 32'sh7fffffff, 1, 1);
		send_row(-1, 0, 0, 16'd32767, 32'sh12345678, 32'sh9abcdef0, 32'sh0fedcba9, 9);
		send_row(3, -4, 12, 16'd40000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, -1);
		send_row(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'd49151,
			32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
		send_row(5, 0, 0, 16'd57344, -1, -1, -1, -1);
		for (int i = 0; i < RANDOM_ROWS; i++) begin
			if (i == RANDOM_ROWS / 3) begin
				tx_idle_pct = 54;
				rx_stall_pct = 25;
			end else if (i == 2 * RANDOM_ROWS / 3) begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			ax = pick_axis();
			ay = pick_axis();
			az = pick_axis();
			if ($urandom_range(3) != 0 && ax == 0 && ay == 0 && az == 0) begin
				ax = $urandom;
			end
			send_row(ax, ay, az, 16'($urandom), pick_elem(), pick_elem(), pick_elem(),
				$urandom);
		end
		in_valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (150) @(negedge clk);
		if (fails == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
